### hdl/sact_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the set-associative cache tag simulator.
// No dependencies.
package sact_pkg;

    localparam int CNT_W   = 32;
    localparam int STAMP_W = 32;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_HIT2
    } state_t;

    localparam logic [1:0] OUT_HIT   = 2'd0;
    localparam logic [1:0] OUT_FILL  = 2'd1;
    localparam logic [1:0] OUT_EVICT = 2'd2;

    localparam logic [1:0] REQ_MODIFY = 2'd2;

    localparam logic [1:0] CFG_SET_BITS    = 2'd0;
    localparam logic [1:0] CFG_OFFSET_BITS = 2'd1;
    localparam logic [1:0] CFG_WAYS        = 2'd2;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        r = (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
        return r;
    endfunction

endpackage

### hdl/set_assoc_cache_tag_sim_core.sv
`timescale 1ns / 1ps
// A request is taken in ST_IDLE, which reads its tag row into a register;
// ST_LOOK registers the result (subject to rsp_ready) and writes the row back
// on a miss; a modify registers a second result from ST_HIT2. A further request
// is taken only after the previous one returns to ST_IDLE.
// Reset: a clearing pass writes every set row, during which no request is
// taken. Depends on sact_pkg.
module set_assoc_cache_tag_sim_core
    import sact_pkg::*;
#(
    parameter int MAX_SET_BITS = 6,
    parameter int MAX_WAYS     = 8,
    parameter int ADDR_WIDTH   = 64
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  logic [1:0]          req_type,
    input  logic [63:0]         address,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output logic [1:0]          outcome,
    output logic                last,
    output logic [CNT_W-1:0]    hit_total,
    output logic [CNT_W-1:0]    miss_total,
    output logic [CNT_W-1:0]    eviction_total,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [5:0]          cfg_data
);

    localparam int SET_W     = MAX_SET_BITS;
    localparam int NUM_SETS  = 1 << SET_W;
    localparam int SB_W      = $clog2(MAX_SET_BITS + 1);
    localparam int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WAY_CNT_W = $clog2(MAX_WAYS + 1);
    localparam int LINE_W    = 1 + ADDR_WIDTH + STAMP_W;
    localparam int ROW_W     = MAX_WAYS * LINE_W;

    state_t state_reg, state_next;

    logic [2:0]            set_bits_reg;
    logic [5:0]            offset_bits_reg;
    logic [3:0]            ways_reg;

    logic [SET_W-1:0]      clr_reg;
    logic [SET_W-1:0]      set_reg;
    logic [ADDR_WIDTH-1:0] tag_reg;
    logic                  modify_reg;
    logic [STAMP_W-1:0]    stamp_reg;
    logic [CNT_W-1:0]      hits_reg;
    logic [CNT_W-1:0]      misses_reg;
    logic [CNT_W-1:0]      evictions_reg;
    logic                  rsp_valid_reg;
    logic [1:0]            outcome_reg;
    logic                  last_reg;

    logic [ROW_W-1:0]      mem [NUM_SETS];
    logic [ROW_W-1:0]      rd_row_reg;

    logic [SB_W-1:0]       sb_eff;
    logic [WAY_CNT_W-1:0]  nw;
    logic [7:0]            tshift;
    logic [ADDR_WIDTH-1:0] addr_m;
    logic [ADDR_WIDTH-1:0] tag_calc;
    logic [ADDR_WIDTH-1:0] set_full;
    logic [SET_W-1:0]      set_calc;

    logic                  hit;
    logic                  free_found;
    logic [WAY_W-1:0]      free_way;
    logic [WAY_W-1:0]      vic_way;
    logic [WAY_W-1:0]      fill_way;
    logic [STAMP_W-1:0]    best_age;
    logic [STAMP_W-1:0]    age;

    logic                  slot_free;
    logic                  accept;
    logic                  mem_rd_en;
    logic                  mem_wr_en;
    logic [SET_W-1:0]      mem_wr_idx;
    logic [ROW_W-1:0]      mem_wr_row;
    logic [ROW_W-1:0]      fill_row;
    logic                  load_rsp;
    logic [1:0]            load_outcome;
    logic                  load_last;

    assign cfg_ready      = 1'b1;
    assign rsp_valid      = rsp_valid_reg;
    assign outcome        = outcome_reg;
    assign last           = last_reg;
    assign hit_total      = hits_reg;
    assign miss_total     = misses_reg;
    assign eviction_total = evictions_reg;

    assign slot_free = !rsp_valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;

    // effective geometry and address split
    always_comb
    begin
        if (int'(set_bits_reg) > MAX_SET_BITS)
        begin
            sb_eff = SB_W'(MAX_SET_BITS);
        end
        else
        begin
            sb_eff = SB_W'(set_bits_reg);
        end
        if (ways_reg == 4'd0)
        begin
            nw = WAY_CNT_W'(1);
        end
        else if (int'(ways_reg) > MAX_WAYS)
        begin
            nw = WAY_CNT_W'(MAX_WAYS);
        end
        else
        begin
            nw = WAY_CNT_W'(ways_reg);
        end
        tshift   = 8'(sb_eff) + 8'(offset_bits_reg);
        addr_m   = address[ADDR_WIDTH-1:0];
        tag_calc = addr_m >> tshift;
        set_full = addr_m >> offset_bits_reg;
        set_calc = set_full[SET_W-1:0] & ~({SET_W{1'b1}} << sb_eff);
    end

    // lookup, free way and oldest way over the read row
    always_comb
    begin
        hit        = 1'b0;
        free_found = 1'b0;
        free_way   = '0;
        vic_way    = '0;
        best_age   = stamp_reg - rd_row_reg[STAMP_W-1:0];
        age        = '0;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            if (WAY_CNT_W'(w) < nw)
            begin
                if (rd_row_reg[w*LINE_W + LINE_W - 1] &&
                    rd_row_reg[w*LINE_W + STAMP_W +: ADDR_WIDTH] == tag_reg)
                begin
                    hit = 1'b1;
                end
                if (!rd_row_reg[w*LINE_W + LINE_W - 1] && !free_found)
                begin
                    free_found = 1'b1;
                    free_way   = WAY_W'(w);
                end
                age = stamp_reg - rd_row_reg[w*LINE_W +: STAMP_W];
                if (age > best_age)
                begin
                    best_age = age;
                    vic_way  = WAY_W'(w);
                end
            end
        end
        fill_way = free_found ? free_way : vic_way;
        fill_row = rd_row_reg;
        fill_row[fill_way*LINE_W +: LINE_W] = {1'b1, tag_reg, stamp_reg};
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == {SET_W{1'b1}})
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                if (slot_free)
                begin
                    state_next = modify_reg ? ST_HIT2 : ST_IDLE;
                end
            end
            ST_HIT2:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs per state
    always_comb
    begin
        req_ready    = 1'b0;
        mem_rd_en    = 1'b0;
        mem_wr_en    = 1'b0;
        mem_wr_idx   = set_reg;
        mem_wr_row   = fill_row;
        load_rsp     = 1'b0;
        load_outcome = OUT_HIT;
        load_last    = 1'b1;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_wr_en  = 1'b1;
                mem_wr_idx = clr_reg;
                mem_wr_row = '0;
            end
            ST_IDLE:
            begin
                req_ready = 1'b1;
                mem_rd_en = req_valid;
            end
            ST_LOOK:
            begin
                load_rsp  = slot_free;
                mem_wr_en = slot_free && !hit;
                load_last = !modify_reg;
                if (hit)
                begin
                    load_outcome = OUT_HIT;
                end
                else if (free_found)
                begin
                    load_outcome = OUT_FILL;
                end
                else
                begin
                    load_outcome = OUT_EVICT;
                end
            end
            ST_HIT2:
            begin
                load_rsp = slot_free;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
        begin
            mem[mem_wr_idx] <= mem_wr_row;
        end
        if (mem_rd_en)
        begin
            rd_row_reg <= mem[set_calc];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            set_reg    <= set_calc;
            tag_reg    <= tag_calc;
            modify_reg <= (req_type == REQ_MODIFY);
        end
        if (load_rsp)
        begin
            outcome_reg <= load_outcome;
            last_reg    <= load_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clr_reg         <= '0;
            set_bits_reg    <= 3'd4;
            offset_bits_reg <= 6'd4;
            ways_reg        <= 4'd1;
            stamp_reg       <= '0;
            hits_reg        <= '0;
            misses_reg      <= '0;
            evictions_reg   <= '0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_SET_BITS:    set_bits_reg    <= cfg_data[2:0];
                    CFG_OFFSET_BITS: offset_bits_reg <= cfg_data;
                    CFG_WAYS:        ways_reg        <= cfg_data[3:0];
                    default:         ;
                endcase
            end
            if (load_rsp)
            begin
                rsp_valid_reg <= 1'b1;
                if (load_outcome == OUT_HIT)
                begin
                    hits_reg <= sat_inc(hits_reg);
                end
                else
                begin
                    misses_reg <= sat_inc(misses_reg);
                    stamp_reg  <= stamp_reg + 1'b1;
                end
                if (load_outcome == OUT_EVICT)
                begin
                    evictions_reg <= sat_inc(evictions_reg);
                end
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_rd_en && mem_wr_en))
        else $error("tag memory read and write in the same cycle");

    a_totals_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> ($stable(hit_total) && $stable(miss_total)
            && $stable(eviction_total)))
        else $error("totals changed while a result waits");

    a_write_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_wr_en && state_reg == ST_LOOK) |-> !hit)
        else $error("tag row written back on a hit");

    a_second_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (load_rsp && state_reg == ST_LOOK && modify_reg) |=> state_reg == ST_HIT2)
        else $error("modify lost its second access");

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for set_assoc_cache_tag_sim_core: directed and random requests,
// checked beat by beat against an in-bench FIFO-replacement tag store predictor.
// Depends on sact_pkg and the core RTL.
module testbench;
    import sact_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int PRED_SETS    = 64;
    localparam int PRED_WAYS    = 8;
    localparam int PRED_LINES   = PRED_SETS * PRED_WAYS;

    typedef struct {
        logic [1:0]  outcome;
        logic        last;
        logic [31:0] hits;
        logic [31:0] misses;
        logic [31:0] evicts;
    } access_result_t;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_ready;
    logic [1:0]  req_type;
    logic [63:0] address;
    logic        rsp_valid;
    logic        rsp_ready;
    logic [1:0]  outcome;
    logic        last;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
    logic [31:0] eviction_total;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [5:0]  cfg_data;

    logic [2:0]  cur_set_bits;
    logic [5:0]  cur_offset_bits;
    logic [3:0]  cur_ways;
    bit          line_valid_q [PRED_LINES];
    logic [63:0] line_tag_q   [PRED_LINES];
    logic [31:0] line_stamp_q [PRED_LINES];
    logic [31:0] stamp_ctr;
    logic [31:0] hit_cnt;
    logic [31:0] miss_cnt;
    logic [31:0] evict_cnt;

    access_result_t pending_results [$];
    access_result_t head_result;

    int err_count;
    int req_count;
    int rsp_count;
    int geometry_count;
    int cycle_count;
    int sender_idle_pct;
    int rsp_stall_pct;

    set_assoc_cache_tag_sim_core i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .req_type       (req_type),
        .address        (address),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .outcome        (outcome),
        .last           (last),
        .hit_total      (hit_total),
        .miss_total     (miss_total),
        .eviction_total (eviction_total),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("[set_assoc_cache_tag_sim_core] ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
    end

    function automatic logic [31:0] bump(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    function automatic int unsigned eff_set_bits();
        return (cur_set_bits > 3'd6) ? 6 : int'(cur_set_bits);
    endfunction

    function automatic int unsigned eff_ways();
        if (cur_ways == 4'd0)
            return 1;
        return (cur_ways > 4'd8) ? 8 : int'(cur_ways);
    endfunction

    function automatic void clear_lines();
        for (int i = 0; i < PRED_LINES; i++)
        begin
            line_valid_q[i] = 1'b0;
            line_tag_q[i]   = '0;
            line_stamp_q[i] = '0;
        end
        cur_set_bits    = 3'd4;
        cur_offset_bits = 6'd4;
        cur_ways        = 4'd1;
        stamp_ctr       = '0;
        hit_cnt         = '0;
        miss_cnt        = '0;
        evict_cnt       = '0;
    endfunction

    function automatic logic [1:0] cache_access(input logic [63:0] a);
        int unsigned sb;
        int unsigned ob;
        int unsigned nw;
        int unsigned tshift;
        int unsigned base;
        int unsigned victim;
        logic [63:0] tg;
        logic [63:0] set_idx;
        logic [31:0] best_age;
        logic [31:0] age;
        sb      = eff_set_bits();
        ob      = cur_offset_bits;
        nw      = eff_ways();
        tshift  = sb + ob;
        tg      = (tshift >= 64) ? 64'd0 : (a >> tshift);
        set_idx = (a >> ob) & ((64'd1 << sb) - 64'd1);
        base    = int'(set_idx[5:0]) * PRED_WAYS;
        for (int w = 0; w < nw; w++)
        begin
            if (line_valid_q[base + w] && line_tag_q[base + w] == tg)
            begin
                hit_cnt = bump(hit_cnt);
                return OUT_HIT;
            end
        end
        miss_cnt = bump(miss_cnt);
        for (int w = 0; w < nw; w++)
        begin
            if (!line_valid_q[base + w])
            begin
                line_valid_q[base + w] = 1'b1;
                line_tag_q[base + w]   = tg;
                line_stamp_q[base + w] = stamp_ctr;
                stamp_ctr              = stamp_ctr + 32'd1;
                return OUT_FILL;
            end
        end
        evict_cnt = bump(evict_cnt);
        victim    = 0;
        best_age  = stamp_ctr - line_stamp_q[base];
        for (int w = 1; w < nw; w++)
        begin
            age = stamp_ctr - line_stamp_q[base + w];
            if (age > best_age)
            begin
                best_age = age;
                victim   = w;
            end
        end
        line_tag_q[base + victim]   = tg;
        line_stamp_q[base + victim] = stamp_ctr;
        stamp_ctr                   = stamp_ctr + 32'd1;
        return OUT_EVICT;
    endfunction

    function automatic void push_access(input logic [63:0] a, input logic is_last);
        access_result_t r;
        r.outcome = cache_access(a);
        r.last    = is_last;
        r.hits    = hit_cnt;
        r.misses  = miss_cnt;
        r.evicts  = evict_cnt;
        pending_results.push_back(r);
    endfunction

    function automatic logic [63:0] rand_addr();
        logic [63:0] full;
        logic [63:0] tg;
        logic [63:0] st;
        int unsigned sb;
        int unsigned ob;
        int          r;
        full = {$urandom, $urandom};
        r    = $urandom_range(0, 99);
        sb   = eff_set_bits();
        ob   = cur_offset_bits;
        if (r < 10)
            return full;
        tg = (r < 15) ? {$urandom, $urandom} : 64'($urandom_range(0, eff_ways() + 3));
        st = (r < 22) ? 64'($urandom) : 64'($urandom_range(0, 3));
        return (tg << (sb + ob)) | ((st & ((64'd1 << sb) - 64'd1)) << ob)
             | (full & ((64'd1 << ob) - 64'd1));
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            err_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            rsp_count++;
            if (pending_results.size() == 0)
            begin
                $error("response beat with no request outstanding");
                err_count++;
            end
            else
            begin
                head_result = pending_results.pop_front();
                check_field("outcome", 32'(head_result.outcome), 32'(outcome));
                check_field("last", 32'(head_result.last), 32'(last));
                check_field("hit_total", head_result.hits, hit_total);
                check_field("miss_total", head_result.misses, miss_total);
                check_field("eviction_total", head_result.evicts, eviction_total);
            end
        end
    end

    task automatic send_req(input logic [1:0] t, input logic [63:0] a);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_type  <= t;
        address   <= a;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        req_count++;
        if (t == REQ_MODIFY)
        begin
            push_access(a, 1'b0);
            push_access(a, 1'b1);
        end
        else
            push_access(a, 1'b1);
    endtask

    task automatic wait_drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [5:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_SET_BITS:    cur_set_bits    = d[2:0];
            CFG_OFFSET_BITS: cur_offset_bits = d;
            CFG_WAYS:        cur_ways        = d[3:0];
            default:         ;
        endcase
    endtask

    task automatic set_geometry(input logic [5:0] sb, input logic [5:0] ob,
                                input logic [5:0] w);
        wait_drain();
        write_cfg(CFG_SET_BITS, sb);
        write_cfg(CFG_OFFSET_BITS, ob);
        write_cfg(CFG_WAYS, w);
        cfg_valid <= 1'b0;
        geometry_count++;
    endtask

    task automatic test_directed();
        sender_idle_pct = 0;
        rsp_stall_pct   = 0;
        send_req(2'd0, 64'h0);
        send_req(2'd0, 64'hF);
        send_req(2'd1, 64'hFFFF_FFFF_FFFF_FFFF);
        send_req(REQ_MODIFY, 64'hFFFF_FFFF_FFFF_FFFF);
        send_req(REQ_MODIFY, 64'h100);
        send_req(2'd3, 64'h0);

        set_geometry(6'd6, 6'd32, 6'd8);
        for (int k = 0; k < 9; k++)
            send_req(2'd0, 64'(k) << 38);
        // shrink and regrow the ways: lines outside the ways in use persist
        set_geometry(6'd6, 6'd32, 6'd2);
        send_req(2'd1, 64'(1) << 38);
        set_geometry(6'd6, 6'd32, 6'd8);
        send_req(2'd0, 64'(7) << 38);

        set_geometry(6'd0, 6'd0, 6'd0);
        send_req(2'd0, 64'h0);
        send_req(2'd0, 64'h1);
        send_req(REQ_MODIFY, 64'h8000_0000_0000_0000);

        set_geometry(6'd7, 6'd63, 6'd15);
        send_req(2'd0, 64'h8000_0000_0000_0000);
        send_req(2'd1, 64'hFFFF_FFFF_FFFF_FFFF);
    endtask

    task automatic test_random_phase(input int n, input int idle_pct, input int stall_pct,
                                     input logic [5:0] sb, input logic [5:0] ob,
                                     input logic [5:0] w, input int pause_every);
        set_geometry(sb, ob, w);
        sender_idle_pct = idle_pct;
        rsp_stall_pct   = stall_pct;
        for (int i = 0; i < n; i++)
        begin
            send_req(2'($urandom_range(0, 3)), rand_addr());
            if (pause_every != 0 && i % pause_every == pause_every - 1)
                wait_drain();
        end
    endtask

    task automatic test_random();
        test_random_phase(250, 0, 0, 6'd1, 6'd1, 6'd1, 0);
        test_random_phase(250, 75, 0, 6'd6, 6'd32, 6'd8, 0);
        test_random_phase(250, 0, 75, 6'd3, 6'd5, 6'd4, 0);
        test_random_phase(250, 28, 28, 6'd2, 6'd6, 6'd3, 60);
        test_random_phase(250, 0, 0, 6'($urandom_range(0, 63)),
                          6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)), 0);
        test_random_phase(250, 75, 0, 6'($urandom_range(0, 7)),
                          6'($urandom_range(0, 12)), 6'($urandom_range(0, 15)), 0);
        test_random_phase(250, 28, 28, 6'($urandom_range(0, 7)),
                          6'($urandom_range(0, 63)), 6'($urandom_range(0, 15)), 40);
    endtask

    initial
    begin
        err_count      = 0;
        req_count      = 0;
        rsp_count      = 0;
        geometry_count = 0;
        cycle_count    = 0;
        sender_idle_pct = 0;
        rsp_stall_pct   = 0;
        clear_lines();
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req_type  <= '0;
        address   <= '0;
        rsp_ready <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random();

        wait_drain();
        repeat (8) @(posedge clk);
        $display("Covered %0d requests and %0d response beats over %0d cache geometries,",
                 req_count, rsp_count, geometry_count);
        $display("including fills, hits, FIFO evictions, modify pairs and idle/stall mixes.");
        if (err_count == 0)
            $display("[set_assoc_cache_tag_sim_core] OK");
        else
            $display("[set_assoc_cache_tag_sim_core] ERROR");
        $finish;
    end

endmodule
